FILE: hw/rtl/lse_pkg.sv
// Package: payload beat types and fixed constants for the LSB stego extractor.
`timescale 1ns / 1ps
package lse_pkg;

  localparam int HEADER_NIBBLES = 8;
  localparam int COVER_W        = 27;
  localparam int LEN_W          = 24;
  localparam int HDR_W          = 4 * HEADER_NIBBLES;
  localparam int K_MAX          = 8;
  // k sits in nibbles 0 and 1; capacity is registered while nibble 2 goes in
  localparam logic [3:0] CAP_NIBBLE = 4'd2;

  typedef struct packed {
    logic [7:0] cover_byte;
    logic       first_of_image;
  } cover_beat_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             last_byte;
    logic             status;
    logic [LEN_W-1:0] payload_length;
  } result_beat_t;

  localparam logic STATUS_PAYLOAD = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

endpackage

FILE: hw/rtl/lsb_stego_extractor_unit.sv
// LSB stego extractor: header capture, bit unpacking and result register.
// Latency: a result appears in the result register the cycle after its cover beat.
// Throughput: one cover beat per cycle; cover_ready = !result_valid || result_ready.
// The header check uses a capacity product registered while the third nibble
// is taken.
// Reset (rst, synchronous): clears stream state, cover_bytes and result_valid.
`timescale 1ns / 1ps
module lsb_stego_extractor_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lse_pkg::COVER_W-1:0] cfg_data,
  input  logic                      cover_valid,
  output logic                      cover_ready,
  input  lse_pkg::cover_beat_t      cover_data,
  output logic                      result_valid,
  input  logic                      result_ready,
  output lse_pkg::result_beat_t     result
);
  import lse_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_e, phase_next;
  logic [COVER_W-1:0] cover_bytes;
  logic [HDR_W-1:0]   header_shift, hdr_e, hdr_ins, header_shift_next;
  logic [3:0]         nibble_count, cnt_e, nibble_count_next;
  logic [6:0]         bit_acc, acc_e, bit_acc_next;
  logic [2:0]         acc_bits, accb_e, acc_bits_next;
  logic [LEN_W-1:0]   bytes_emitted, emit_e, bytes_emitted_next;
  logic [COVER_W:0]   cap;
  logic               k_ok;
  logic [COVER_W+3:0] cap_prod;
  logic               take, first;
  logic               res_load;
  result_beat_t       res_next;
  logic [3:0]         k;
  logic [7:0]         mask;
  logic [14:0]        merged;
  logic [3:0]         total;
  logic [LEN_W-1:0]   len_ins;
  logic [COVER_W:0]   need;

  assign cfg_ready   = 1'b1;
  assign cover_ready = !result_valid || result_ready;
  assign take        = cover_valid && cover_ready;
  assign first       = cover_data.first_of_image;

  // new image clears the stream before this beat is used
  assign phase_e = first ? PH_HEADER : phase;
  assign cnt_e   = first ? '0 : nibble_count;
  assign hdr_e   = first ? '0 : header_shift;
  assign acc_e   = first ? '0 : bit_acc;
  assign accb_e  = first ? '0 : acc_bits;
  assign emit_e  = first ? '0 : bytes_emitted;

  assign k        = hdr_e[3:0];
  assign cap_prod = {4'b0, cover_bytes} * {{COVER_W{1'b0}}, header_shift[3:0]};
  assign hdr_ins  = hdr_e | ({{(HDR_W-4){1'b0}}, cover_data.cover_byte[3:0]}
                             << {cnt_e[2:0], 2'b00});
  assign len_ins  = hdr_ins[HDR_W-1:8];
  assign need     = {{(COVER_W+1-LEN_W){1'b0}}, len_ins} + (COVER_W+1)'(K_MAX);
  assign mask     = 8'hFF >> (4'(K_MAX) - k);
  assign merged   = {8'b0, acc_e} | ({7'b0, cover_data.cover_byte & mask} << accb_e);
  assign total    = {1'b0, accb_e} + k;

  always_comb begin
    phase_next         = phase_e;
    header_shift_next  = hdr_e;
    nibble_count_next  = cnt_e;
    bit_acc_next       = acc_e;
    acc_bits_next      = accb_e;
    bytes_emitted_next = emit_e;
    res_load           = 1'b0;
    res_next           = '0;
    case (phase_e)
      PH_HEADER: begin
        header_shift_next = hdr_ins;
        nibble_count_next = cnt_e + 4'd1;
        if (cnt_e == 4'(HEADER_NIBBLES - 1)) begin
          if (k_ok && (len_ins != '0) && (need <= cap)) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next              = PH_DONE;
            res_load                = 1'b1;
            res_next.status         = STATUS_INVALID;
            res_next.last_byte      = 1'b1;
            res_next.payload_length = len_ins;
          end
        end
      end
      PH_PAYLOAD: begin
        acc_bits_next = total[2:0];
        if (total[3]) begin
          bit_acc_next            = merged[14:8];
          bytes_emitted_next      = emit_e + LEN_W'(1);
          res_load                = 1'b1;
          res_next.payload_byte   = merged[7:0];
          res_next.status         = STATUS_PAYLOAD;
          res_next.payload_length = hdr_e[HDR_W-1:8];
          res_next.last_byte      = (bytes_emitted_next == hdr_e[HDR_W-1:8]);
          if (res_next.last_byte) begin
            phase_next = PH_DONE;
          end
        end else begin
          bit_acc_next = merged[6:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cover_bytes   <= '0;
      phase         <= PH_HEADER;
      header_shift  <= '0;
      nibble_count  <= '0;
      bit_acc       <= '0;
      acc_bits      <= '0;
      bytes_emitted <= '0;
      cap           <= '0;
      k_ok          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cover_bytes <= cfg_data;
      end
      if (take) begin
        phase         <= phase_next;
        header_shift  <= header_shift_next;
        nibble_count  <= nibble_count_next;
        bit_acc       <= bit_acc_next;
        acc_bits      <= acc_bits_next;
        bytes_emitted <= bytes_emitted_next;
        if (phase_e == PH_HEADER && cnt_e == CAP_NIBBLE) begin
          cap  <= cap_prod[COVER_W+3:3];
          k_ok <= (header_shift[7:0] != 8'd0) && (header_shift[7:0] <= 8'(K_MAX));
        end
      end
      if (take && res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_load) begin
      result <= res_next;
    end
  end

  a_k_legal: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> (header_shift[3:0] != 4'd0 && header_shift[3:0] <= 4'(K_MAX)))
    else $error("payload phase with illegal bits per cover byte");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_emitted < header_shift[HDR_W-1:8])
    else $error("emitted count reached length without finishing");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    take && res_load && res_next.last_byte |=> phase == PH_DONE)
    else $error("last beat did not end the stream");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DONE && !first |-> !res_load)
    else $error("result raised after stream finished");

endmodule
